// File: rtl/frb_pkg.sv
// Shared types and constants for the frame reorder and release buffer.
package frb_pkg;

  localparam int DEPTH_DEF = 64;
  localparam int ORDER_W = 32;
  localparam int BYTES_W = 24;
  localparam int DATA_W = 56;
  localparam int IN_USER_W = 2;
  localparam int OUT_USER_W = 3;
  localparam int Q_ENTRIES = 2;
  localparam logic [BYTES_W-1:0] BYTES_MAX = {BYTES_W{1'b1}};
  localparam logic [BYTES_W:0] DELIM_BYTES = (BYTES_W + 1)'(2);

  typedef struct packed {
    logic eos;
    logic show_ex;
    logic show;
    logic [BYTES_W-1:0] bytes;
  } frb_frame_t;

  localparam int FRAME_W = $bits(frb_frame_t);

endpackage

// File: rtl/frb_front.sv
// Input side: accepts frames and reduces the frame order number to a slot index.
module frb_front import frb_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     s_tvalid,
  output logic                                     s_tready,
  input  logic [DATA_W-1:0]                        s_tdata,  // frame_order, frame_bytes
  input  logic [IN_USER_W-1:0]                     s_tuser,  // show_frame, show_existing
  input  logic                                     s_tlast,
  output logic                                     push_valid,
  input  logic                                     push_ready,
  output logic [$clog2(QUEUE_DEPTH)+FRAME_W-1:0]   push_data
);

  localparam int REM_W = $clog2(QUEUE_DEPTH);
  localparam int SHIFT = ORDER_W + REM_W;
  localparam int RECIP_W = ORDER_W + 1;
  localparam int LO_W = RECIP_W / 2;
  localparam int HI_W = RECIP_W - LO_W;
  localparam int PROD_W = ORDER_W + RECIP_W;
  localparam logic [63:0] RECIP_FULL = (64'd1 << SHIFT) / 64'(QUEUE_DEPTH);
  localparam logic [LO_W-1:0] RECIP_LO = RECIP_FULL[LO_W-1:0];
  localparam logic [HI_W-1:0] RECIP_HI = RECIP_FULL[LO_W +: HI_W];
  localparam logic [REM_W:0] DEPTH_V = (REM_W + 1)'(QUEUE_DEPTH);
  localparam logic [1:0] LAST_STEP = 2'd3;

  logic busy;
  logic done;
  logic [1:0] step;
  logic [ORDER_W-1:0] order_num;
  logic [ORDER_W+LO_W-1:0] prod_lo;
  logic [ORDER_W+HI_W-1:0] prod_hi;
  logic [PROD_W-1:0] prod;
  logic [REM_W:0] quot_lo;
  logic [REM_W:0] rem_est;
  logic [REM_W-1:0] rem;
  frb_frame_t frame;
  logic accept;

  assign s_tready = !busy;
  assign accept = s_tvalid && s_tready;
  assign push_valid = done;
  assign push_data = {rem, frame};
  assign prod = {prod_hi, {LO_W{1'b0}}} + PROD_W'(prod_lo);

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      step <= '0;
    end else if (accept) begin
      busy <= 1'b1;
      done <= 1'b0;
      step <= '0;
    end else if (busy && !done) begin
      step <= step + 1'b1;
      if (step == LAST_STEP) begin
        done <= 1'b1;
      end
    end else if (done && push_ready) begin
      busy <= 1'b0;
      done <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      order_num <= s_tdata[ORDER_W-1:0];
      frame.bytes <= s_tdata[ORDER_W +: BYTES_W];
      frame.show <= s_tuser[0];
      frame.show_ex <= s_tuser[1];
      frame.eos <= s_tlast;
    end
  end

  // The quotient estimate from the reciprocal is exact or one low, so the
  // remainder estimate lies below twice the depth and needs one correction.
  always_ff @(posedge clk) begin
    prod_lo <= (ORDER_W + LO_W)'(order_num) * (ORDER_W + LO_W)'(RECIP_LO);
    prod_hi <= (ORDER_W + HI_W)'(order_num) * (ORDER_W + HI_W)'(RECIP_HI);
    quot_lo <= prod[SHIFT +: REM_W + 1];
    rem_est <= order_num[REM_W:0] - quot_lo * DEPTH_V;
    rem <= (rem_est >= DEPTH_V) ? rem_est[REM_W-1:0] - DEPTH_V[REM_W-1:0]
                                : rem_est[REM_W-1:0];
  end

endmodule

// File: rtl/frb_queue.sv
// Short queue of classified frames between the input side and the release side.
module frb_queue import frb_pkg::*; #(
  parameter int WIDTH = FRAME_W
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push_valid,
  output logic             push_ready,
  input  logic [WIDTH-1:0] push_data,
  output logic             pop_valid,
  input  logic             pop_ready,
  output logic [WIDTH-1:0] pop_data
);

  localparam int PTR_W = $clog2(Q_ENTRIES);
  localparam int CNT_W = $clog2(Q_ENTRIES + 1);

  logic [WIDTH-1:0] entries [Q_ENTRIES];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic do_push;
  logic do_pop;

  assign push_ready = count != CNT_W'(Q_ENTRIES);
  assign pop_valid = count != '0;
  assign pop_data = entries[rd_ptr];
  assign do_push = push_valid && push_ready;
  assign do_pop = pop_valid && pop_ready;

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_data;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(Q_ENTRIES - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(Q_ENTRIES - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// File: rtl/frb_back.sv
// Release side: stores frames in their slots and drains valid slots in decode order.
module frb_back import frb_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic                                     clk,
  input  logic                                     rst,
  input  logic                                     q_valid,
  output logic                                     q_pop,
  input  logic [$clog2(QUEUE_DEPTH)+FRAME_W-1:0]   q_data,
  output logic                                     m_tvalid,
  input  logic                                     m_tready,
  output logic [DATA_W-1:0]                        m_tdata,  // released_order, final_bytes
  output logic [OUT_USER_W-1:0]                    m_tuser,  // has_delimiter, existing_delimiter, end_flag
  output logic                                     m_tlast
);

  localparam int IDX_W = $clog2(QUEUE_DEPTH);
  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_CHECK = 2'd1;
  localparam logic [1:0] ST_EMIT = 2'd2;

  frb_frame_t mem [QUEUE_DEPTH];
  frb_frame_t rd_frame;
  frb_frame_t q_frame;
  logic [IDX_W-1:0] q_idx;
  logic [QUEUE_DEPTH-1:0] slot_valid;
  logic [IDX_W-1:0] head_slot;
  logic [IDX_W-1:0] head_inc;
  logic [ORDER_W-1:0] head_order;
  logic pending;
  logic [1:0] state;
  logic load;
  logic [BYTES_W:0] sum;
  logic [BYTES_W-1:0] final_bytes;

  assign q_frame = q_data[FRAME_W-1:0];
  assign q_idx = q_data[FRAME_W +: IDX_W];
  assign q_pop = (state == ST_IDLE) && q_valid;
  assign load = (state == ST_EMIT) && (!m_tvalid || m_tready);
  assign head_inc = (head_slot == IDX_W'(QUEUE_DEPTH - 1)) ? '0 : head_slot + 1'b1;

  always_comb begin
    sum = {1'b0, rd_frame.bytes};
    if (rd_frame.show_ex) begin
      sum = sum + DELIM_BYTES;
    end
    if (pending) begin
      sum = sum + DELIM_BYTES;
    end
    final_bytes = (sum > {1'b0, BYTES_MAX}) ? BYTES_MAX : sum[BYTES_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (q_pop) begin
      mem[q_idx] <= q_frame;
    end
    rd_frame <= mem[head_slot];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      slot_valid <= '0;
      head_slot <= '0;
      head_order <= '0;
      pending <= 1'b0;
      m_tvalid <= 1'b0;
    end else begin
      if (load) begin
        m_tvalid <= 1'b1;
      end else if (m_tready) begin
        m_tvalid <= 1'b0;
      end
      case (state)
        ST_IDLE: begin
          if (q_valid) begin
            slot_valid[q_idx] <= 1'b1;
            state <= ST_CHECK;
          end
        end
        ST_CHECK: begin
          state <= slot_valid[head_slot] ? ST_EMIT : ST_IDLE;
        end
        ST_EMIT: begin
          if (load) begin
            slot_valid[head_slot] <= 1'b0;
            head_slot <= head_inc;
            head_order <= head_order + 1'b1;
            pending <= rd_frame.show || rd_frame.show_ex;
            state <= ST_CHECK;
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      m_tdata <= {final_bytes, head_order};
      m_tuser <= {rd_frame.eos, rd_frame.show_ex, pending};
      m_tlast <= !slot_valid[head_inc];
    end
  end

  a_emit_valid: assert property (@(posedge clk) disable iff (rst)
    state == ST_EMIT |-> slot_valid[head_slot])
    else $error("release started on an empty slot");

  a_order_step: assert property (@(posedge clk) disable iff (rst)
    load |=> head_order == $past(head_order) + 1'b1)
    else $error("head order did not advance on release");

  a_slot_cleared: assert property (@(posedge clk) disable iff (rst)
    load |=> !slot_valid[$past(head_slot)])
    else $error("released slot still valid");

  a_no_write_in_drain: assert property (@(posedge clk) disable iff (rst)
    q_pop |-> state == ST_IDLE && !m_tvalid || state == ST_IDLE)
    else $error("frame written while draining");

endmodule

// File: rtl/frame_reorder_release_buffer.sv
// Top level of the frame reorder and in-order release buffer.
// Each accepted item is one completed frame; it is placed in slot (frame order number mod
// QUEUE_DEPTH), after which the run of consecutive valid slots from the head is released
// in decode order, one result item per frame, with tlast on the final one for that input.
// The input side registers an item and then finds its slot (a reciprocal multiplication
// in two halves, a quotient register, a remainder estimate and one correcting subtraction)
// and hands it to the queue; it takes no new item until the last one has been handed on.
// The release side stores a frame and tests the head slot, then releases each frame via
// the registered slot-memory read and the output register. A two-entry queue between the
// sides lets the input side take further items while a drain is under way.
module frame_reorder_release_buffer import frb_pkg::*; #(
  parameter int QUEUE_DEPTH = DEPTH_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_tvalid,
  output logic                  s_tready,
  input  logic [DATA_W-1:0]     s_tdata,  // frame_order, frame_bytes
  input  logic [IN_USER_W-1:0]  s_tuser,  // show_frame, show_existing
  input  logic                  s_tlast,
  output logic                  m_tvalid,
  input  logic                  m_tready,
  output logic [DATA_W-1:0]     m_tdata,  // released_order, final_bytes
  output logic [OUT_USER_W-1:0] m_tuser,  // has_delimiter, existing_delimiter, end_flag
  output logic                  m_tlast
);

  localparam int ENTRY_W = $clog2(QUEUE_DEPTH) + FRAME_W;

  logic push_valid;
  logic push_ready;
  logic [ENTRY_W-1:0] push_data;
  logic pop_valid;
  logic pop_ready;
  logic [ENTRY_W-1:0] pop_data;

  frb_front #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_front (
    .clk        (clk),
    .rst        (rst),
    .s_tvalid   (s_tvalid),
    .s_tready   (s_tready),
    .s_tdata    (s_tdata),
    .s_tuser    (s_tuser),
    .s_tlast    (s_tlast),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data)
  );

  frb_queue #(.WIDTH(ENTRY_W)) u_queue (
    .clk        (clk),
    .rst        (rst),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_data  (push_data),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_data   (pop_data)
  );

  frb_back #(.QUEUE_DEPTH(QUEUE_DEPTH)) u_back (
    .clk      (clk),
    .rst      (rst),
    .q_valid  (pop_valid),
    .q_pop    (pop_ready),
    .q_data   (pop_data),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tuser  (m_tuser),
    .m_tlast  (m_tlast)
  );

endmodule

// File: tb/testbench.sv
// Self-checking testbench for the frame reorder and in-order release buffer.
module testbench;
  import frb_pkg::*;

  localparam int DEPTH = DEPTH_DEF;
  localparam int CYCLE_LIMIT = 1500000;
  localparam int HOLD_CYCLES = 3000;
  localparam int SETTLE_CYCLES = 200;
  localparam int PHASE_FRAMES = 90;

  typedef struct {
    logic [ORDER_W-1:0] order;
    logic [BYTES_W-1:0] bytes;
    logic show;
    logic show_ex;
    logic eos;
  } frame_in_t;

  typedef struct {
    logic [ORDER_W-1:0] order;
    logic [BYTES_W-1:0] bytes;
    logic had_delim;
    logic ex_delim;
    logic end_flag;
    logic is_last;
  } frame_release_t;

  typedef struct packed {
    logic [ORDER_W-1:0] order;
    logic [BYTES_W-1:0] bytes;
    logic show;
    logic show_ex;
    logic eos;
    logic typed;
    logic [ORDER_W-1:0] w_order;
    logic [BYTES_W-1:0] w_bytes;
    logic w_had;
    logic w_ex;
    logic w_end;
  } dir_row_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic s_tvalid = 1'b0;
  logic s_tready;
  logic [DATA_W-1:0] s_tdata = '0;
  logic [IN_USER_W-1:0] s_tuser = '0;
  logic s_tlast = 1'b0;
  logic m_tvalid;
  logic m_tready = 1'b0;
  logic [DATA_W-1:0] m_tdata;
  logic [OUT_USER_W-1:0] m_tuser;
  logic m_tlast;

  frame_reorder_release_buffer #(.QUEUE_DEPTH(DEPTH)) i_dut (
    .clk(clk),
    .rst(rst),
    .s_tvalid(s_tvalid),
    .s_tready(s_tready),
    .s_tdata(s_tdata),   // frame_order, frame_bytes
    .s_tuser(s_tuser),   // show_frame, show_existing
    .s_tlast(s_tlast),
    .m_tvalid(m_tvalid),
    .m_tready(m_tready),
    .m_tdata(m_tdata),   // released_order, final_bytes
    .m_tuser(m_tuser),   // has_delimiter, existing_delimiter, end_flag
    .m_tlast(m_tlast)
  );

  always begin
    clk = 1'b1;
    #6;
    clk = 1'b0;
    #6;
  end

  // Shadow copy of the buffer.
  frb_frame_t slot_frame [DEPTH];
  bit slot_full [DEPTH];
  int head_slot = 0;
  logic [ORDER_W-1:0] head_order = '0;
  bit delim_pending = 1'b0;

  frame_release_t releases_due [$];

  int errors = 0;
  int cycles = 0;
  int frames_sent = 0;
  int frames_released = 0;
  int deepest_drain = 0;
  int saturated = 0;
  int idle_pct = 0;
  int stall_pct = 0;
  logic hold_req = 1'b0;

  dir_row_t directed_rows [0:14] = '{
    '{32'h0000_0000, 24'h000000, 1'b0, 1'b0, 1'b0,
      1'b1, 32'h0000_0000, 24'h000000, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0001, 24'hFFFFFF, 1'b1, 1'b0, 1'b1,
      1'b1, 32'h0000_0001, 24'hFFFFFF, 1'b0, 1'b0, 1'b1},
    '{32'h0000_0002, 24'hFFFFFE, 1'b0, 1'b1, 1'b0,
      1'b1, 32'h0000_0002, 24'hFFFFFF, 1'b1, 1'b1, 1'b0},
    '{32'h0000_0003, 24'd100, 1'b0, 1'b0, 1'b0,
      1'b1, 32'h0000_0003, 24'd102, 1'b1, 1'b0, 1'b0},
    '{32'h0000_0005, 24'd10, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0006, 24'd20, 1'b0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'hFFFF_FFC4, 24'd30, 1'b0, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0008, 24'd1, 1'b1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0009, 24'd1, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0049, 24'd2, 1'b1, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_0007, 24'h800000, 1'b0, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'hFFFF_FFFF, 24'd5, 1'b1, 1'b1, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h0000_000A, 24'hAAAAAA, 1'b1, 1'b1, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'h5555_554B, 24'h555555, 1'b0, 1'b0, 1'b1, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0},
    '{32'hAAAA_AA8C, 24'hFFFFFF, 1'b1, 1'b0, 1'b0, 1'b0, '0, '0, 1'b0, 1'b0, 1'b0}
  };

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("[%0d] mismatch on %s: got 0x%0h, expected 0x%0h", cycles, what, got, want);
    errors++;
  endtask

  function automatic int predict_releases(input frame_in_t f);
    int slot;
    int n;
    logic [BYTES_W+1:0] len;
    frb_frame_t fr;
    frame_release_t r;
    slot = int'(f.order % DEPTH);
    fr.eos = f.eos;
    fr.show_ex = f.show_ex;
    fr.show = f.show;
    fr.bytes = f.bytes;
    slot_frame[slot] = fr;
    slot_full[slot] = 1'b1;
    n = 0;
    while (n < DEPTH && slot_full[head_slot]) begin
      fr = slot_frame[head_slot];
      len = {2'b00, fr.bytes};
      if (fr.show_ex) len = len + 2'd2;
      if (delim_pending) len = len + 2'd2;
      if (len > {2'b00, BYTES_MAX}) begin
        len = {2'b00, BYTES_MAX};
        saturated++;
      end
      r.order = head_order;
      r.bytes = len[BYTES_W-1:0];
      r.had_delim = delim_pending;
      r.ex_delim = fr.show_ex;
      r.end_flag = fr.eos;
      r.is_last = 1'b0;
      releases_due.push_back(r);
      delim_pending = fr.show | fr.show_ex;
      slot_full[head_slot] = 1'b0;
      head_order = head_order + 1;
      head_slot = (head_slot + 1 >= DEPTH) ? 0 : head_slot + 1;
      n++;
    end
    if (n > 0) releases_due[releases_due.size() - 1].is_last = 1'b1;
    if (n > deepest_drain) deepest_drain = n;
    return n;
  endfunction

  function automatic frame_in_t random_frame(input logic [ORDER_W-1:0] order);
    frame_in_t f;
    f.order = order;
    case ($urandom_range(0, 9))
      0: f.bytes = BYTES_W'($urandom_range(16777200, 16777215));
      1: f.bytes = BYTES_W'($urandom());
      default: f.bytes = BYTES_W'($urandom_range(0, 4000));
    endcase
    f.show = 1'($urandom_range(0, 1));
    f.show_ex = ($urandom_range(0, 3) == 0);
    f.eos = ($urandom_range(0, 9) == 0);
    return f;
  endfunction

  task automatic send_frame(input frame_in_t f, output int n);
    while ($urandom_range(0, 99) < idle_pct) begin
      s_tvalid <= 1'b0;
      @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata <= {f.bytes, f.order};
    s_tuser <= {f.show_ex, f.show};
    s_tlast <= f.eos;
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    n = predict_releases(f);
    frames_sent++;
  endtask

  // A run of consecutive decode orders from the current head, sent shuffled.
  task automatic send_window(input int size, input bit head_last);
    logic [ORDER_W-1:0] base;
    logic [ORDER_W-1:0] seq [$];
    logic [ORDER_W-1:0] tmp;
    int j;
    int n;
    base = head_order;
    for (int k = 0; k < size; k++) begin
      seq.push_back(ORDER_W'(base + ORDER_W'(k) + {$urandom(), 6'b0}));
    end
    for (int k = size - 1; k > 0; k--) begin
      j = $urandom_range(0, k);
      tmp = seq[k];
      seq[k] = seq[j];
      seq[j] = tmp;
    end
    if (head_last) begin
      for (int k = 0; k < size; k++) begin
        if (seq[k][5:0] == base[5:0]) begin
          tmp = seq[k];
          seq[k] = seq[size - 1];
          seq[size - 1] = tmp;
        end
      end
    end
    foreach (seq[k]) send_frame(random_frame(seq[k]), n);
  endtask

  task automatic run_phase(input int target);
    int start;
    int size;
    int n;
    start = frames_sent;
    while (frames_sent - start < target) begin
      if ($urandom_range(0, 9) < 2) begin
        send_frame(random_frame($urandom()), n);
      end else begin
        case ($urandom_range(0, 19))
          0: size = DEPTH;
          1, 2, 3, 4: size = $urandom_range(9, 24);
          default: size = $urandom_range(1, 8);
        endcase
        send_window(size, $urandom_range(0, 9) < 3);
      end
    end
    s_tvalid <= 1'b0;
    while (releases_due.size() != 0) @(posedge clk);
  endtask

  always @(posedge clk) begin
    cycles++;
    if (cycles > CYCLE_LIMIT) begin
      $display("Run stopped after %0d cycles with %0d results outstanding",
               cycles, releases_due.size());
      $display("FAIL frame_reorder_release_buffer");
      $finish;
    end
  end

  // Receiver: random stalls, plus one long hold-off on request.
  initial begin
    forever begin
      @(posedge clk);
      if (hold_req) begin
        m_tready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk);
      end
      m_tready <= ($urandom_range(0, 99) >= stall_pct);
    end
  end

  always @(posedge clk) begin
    frame_release_t want;
    if (!rst && m_tvalid && m_tready) begin
      if (releases_due.size() == 0) begin
        report_mismatch("unexpected result, released_order", m_tdata[ORDER_W-1:0], '0);
      end else begin
        want = releases_due.pop_front();
        frames_released++;
        if (m_tdata[ORDER_W-1:0] !== want.order)
          report_mismatch("released_order", m_tdata[ORDER_W-1:0], want.order);
        if (m_tdata[ORDER_W+BYTES_W-1:ORDER_W] !== want.bytes)
          report_mismatch("final_bytes", 32'(m_tdata[ORDER_W+BYTES_W-1:ORDER_W]),
                          32'(want.bytes));
        if (m_tuser[0] !== want.had_delim)
          report_mismatch("has_delimiter", 32'(m_tuser[0]), 32'(want.had_delim));
        if (m_tuser[1] !== want.ex_delim)
          report_mismatch("existing_delimiter", 32'(m_tuser[1]), 32'(want.ex_delim));
        if (m_tuser[2] !== want.end_flag)
          report_mismatch("end_flag", 32'(m_tuser[2]), 32'(want.end_flag));
        if (m_tlast !== want.is_last)
          report_mismatch("last", 32'(m_tlast), 32'(want.is_last));
      end
    end
  end

  initial begin
    frame_in_t f;
    frame_release_t w;
    int n;
    for (int k = 0; k < DEPTH; k++) slot_full[k] = 1'b0;
    repeat (9) @(posedge clk);
    rst <= 1'b0;
    stall_pct = 30;
    @(posedge clk);

    foreach (directed_rows[k]) begin
      f.order = directed_rows[k].order;
      f.bytes = directed_rows[k].bytes;
      f.show = directed_rows[k].show;
      f.show_ex = directed_rows[k].show_ex;
      f.eos = directed_rows[k].eos;
      send_frame(f, n);
      if (directed_rows[k].typed) begin
        if (n != 1) begin
          report_mismatch("directed result count", n, 1);
        end else begin
          w.order = directed_rows[k].w_order;
          w.bytes = directed_rows[k].w_bytes;
          w.had_delim = directed_rows[k].w_had;
          w.ex_delim = directed_rows[k].w_ex;
          w.end_flag = directed_rows[k].w_end;
          w.is_last = 1'b1;
          releases_due[releases_due.size() - 1] = w;
        end
      end
    end
    s_tvalid <= 1'b0;
    while (releases_due.size() != 0) @(posedge clk);

    idle_pct = 20;
    stall_pct = 70;
    hold_req <= 1'b1;
    @(posedge clk);
    hold_req <= 1'b0;
    send_window(24, 1'b0);
    run_phase(PHASE_FRAMES);

    idle_pct = 70;
    stall_pct = 20;
    run_phase(PHASE_FRAMES);

    idle_pct = 0;
    stall_pct = 0;
    send_window(DEPTH, 1'b1);
    run_phase(PHASE_FRAMES);

    repeat (SETTLE_CYCLES) @(posedge clk);
    $display("Sent %0d frames, %0d released in order; longest drain %0d frames.",
             frames_sent, frames_released, deepest_drain);
    $display("%0d lengths saturated; %0d mismatches over %0d cycles.",
             saturated, errors, cycles);
    if (errors == 0) begin
      $display("PASS frame_reorder_release_buffer");
    end else begin
      $display("FAIL frame_reorder_release_buffer");
    end
    $finish;
  end

endmodule
